### hw/rtl/gregorian_date_stepper_defines.svh
// ----------------------------------------------------------------------------
// Gregorian date stepper: assertion macros
// Shared concurrent-assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_STEPPER_DEFINES_SVH
`define GREGORIAN_DATE_STEPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that a condition implies a consequence in the same cycle.
`define GDS_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("gregorian_date_stepper: implication check failed");
// Check that a condition implies a consequence a fixed number of cycles later.
`define GDS_ASSERT_LATER(label, clk, rst_n, cond, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> ##dly (cons)) \
        else $error("gregorian_date_stepper: latency check failed");
`else
`define GDS_ASSERT_IMPL(label, clk, rst_n, cond, cons)
`define GDS_ASSERT_LATER(label, clk, rst_n, cond, dly, cons)
`endif

`endif

### hw/rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Types, constants and the month length function of the date stepper.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam int YEAR_MAX       = 9999;
    localparam int YEAR_FIELD_MAX = (1 << YEAR_W) - 1;
    localparam logic [YEAR_W-1:0] YEAR_LIMIT =
        YEAR_W'((YEAR_MAX < YEAR_FIELD_MAX) ? YEAR_MAX : YEAR_FIELD_MAX);
    localparam logic [YEAR_W-1:0] YEAR_FIRST = YEAR_W'(1);

    // floor(y / 25) = (y * RECIP25) >> RECIP_SHIFT, exact for all 14-bit y
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP25 =
        RECIP_W'(((1 << RECIP_SHIFT) + 24) / 25);
    localparam int PROD_W = YEAR_W + RECIP_W;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0] DAY_LAST_DEC = DAY_W'(31);

    typedef enum logic [0:0] {
        ACT_NEXT = 1'b0,
        ACT_PREV = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MONTH = 2'd1,
        ST_BAD_YEAR  = 2'd2
    } t_status;

    typedef struct packed {
        logic               action;
        logic [DAY_W-1:0]   day_in;
        logic [MONTH_W-1:0] month_in;
        logic [YEAR_W-1:0]  year_in;
    } t_in_item;

    typedef struct packed {
        logic [DAY_W-1:0]   day_out;
        logic [MONTH_W-1:0] month_out;
        logic [YEAR_W-1:0]  year_out;
        logic [1:0]         status;
    } t_out_item;

    // after the reciprocal multiply
    typedef struct packed {
        logic           valid;
        t_in_item       item;
        logic [Q_W-1:0] q25;
    } t_s1;

    // after the leap test and month length lookup
    typedef struct packed {
        logic             valid;
        t_in_item         item;
        logic             month_ok;
        logic             year_ok;
        logic [DAY_W-1:0] len_cur;
        logic [DAY_W-1:0] len_prev;
    } t_s2;

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        len = DAY_W'(31);
        if (m == MONTH_FEB) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else if (m == MONTH_APR || m == MONTH_JUN ||
                     m == MONTH_SEP || m == MONTH_NOV) begin
            len = DAY_W'(30);
        end
        return len;
    endfunction

endpackage

### hw/rtl/gds_year_div.sv
// ----------------------------------------------------------------------------
// gds_year_div
// Stage 1: register the item with the year divided by 25.
// ----------------------------------------------------------------------------
module gds_year_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gds_pkg::t_in_item i_item,
    output gds_pkg::t_s1      o_stage
);

    logic [gds_pkg::PROD_W-1:0] prod;

    assign prod = gds_pkg::PROD_W'(i_item.year_in) * gds_pkg::PROD_W'(gds_pkg::RECIP25);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_stage.valid <= 1'b0;
        end else begin
            o_stage.valid <= i_valid;
        end
        o_stage.item <= i_item;
        o_stage.q25  <= prod[gds_pkg::PROD_W-1:gds_pkg::RECIP_SHIFT];
    end

endmodule

### hw/rtl/gds_month_len.sv
// ----------------------------------------------------------------------------
// gds_month_len
// Stage 2: leap year test, range checks and month lengths.
// ----------------------------------------------------------------------------
module gds_month_len (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  gds_pkg::t_s1 i_stage,
    output gds_pkg::t_s2 o_stage
);

    logic [gds_pkg::YEAR_W-1:0]  year;
    logic [gds_pkg::MONTH_W-1:0] month;
    logic [gds_pkg::MONTH_W-1:0] month_prev;
    logic [gds_pkg::YEAR_W-1:0]  q_times_25;
    logic                        div25;
    logic                        leap;

    assign year  = i_stage.item.year_in;
    assign month = i_stage.item.month_in;

    // q * 25 = q * 16 + q * 8 + q
    assign q_times_25 = (gds_pkg::YEAR_W'(i_stage.q25) << 4)
                      + (gds_pkg::YEAR_W'(i_stage.q25) << 3)
                      + gds_pkg::YEAR_W'(i_stage.q25);
    assign div25 = (q_times_25 == year);

    // by 4, and not by 100 unless by 400 (by 100 = by 4 and by 25)
    assign leap = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

    assign month_prev = (month == gds_pkg::MONTH_JAN) ? gds_pkg::MONTH_DEC
                                                      : month - gds_pkg::MONTH_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_stage.valid <= 1'b0;
        end else begin
            o_stage.valid <= i_stage.valid;
        end
        o_stage.item     <= i_stage.item;
        o_stage.month_ok <= (month >= gds_pkg::MONTH_JAN) && (month <= gds_pkg::MONTH_DEC);
        o_stage.year_ok  <= (year >= gds_pkg::YEAR_FIRST) && (year <= gds_pkg::YEAR_LIMIT);
        o_stage.len_cur  <= gds_pkg::days_in(month, leap);
        o_stage.len_prev <= gds_pkg::days_in(month_prev, leap);
    end

endmodule

### hw/rtl/gds_step.sv
// ----------------------------------------------------------------------------
// gds_step
// Stage 3: advance or step back the date and register the result.
// ----------------------------------------------------------------------------
module gds_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gds_pkg::t_s2       i_stage,
    output logic               o_valid,
    output gds_pkg::t_out_item o_result
);

    logic [gds_pkg::DAY_W-1:0]   d;
    logic [gds_pkg::MONTH_W-1:0] m;
    logic [gds_pkg::YEAR_W-1:0]  y;
    gds_pkg::t_out_item          n_result;

    assign d = i_stage.item.day_in;
    assign m = i_stage.item.month_in;
    assign y = i_stage.item.year_in;

    always_comb begin
        n_result.day_out   = d;
        n_result.month_out = m;
        n_result.year_out  = y;
        n_result.status    = gds_pkg::ST_OK;
        if (!i_stage.month_ok) begin
            n_result.status = gds_pkg::ST_BAD_MONTH;
        end else if (!i_stage.year_ok) begin
            n_result.status = gds_pkg::ST_BAD_YEAR;
        end else if (i_stage.item.action == gds_pkg::ACT_NEXT) begin
            if (d < i_stage.len_cur) begin
                n_result.day_out = d + gds_pkg::DAY_W'(1);
            end else if (m != gds_pkg::MONTH_DEC) begin
                n_result.day_out   = gds_pkg::DAY_FIRST;
                n_result.month_out = m + gds_pkg::MONTH_W'(1);
            end else if (y == gds_pkg::YEAR_LIMIT) begin
                n_result.status = gds_pkg::ST_BAD_YEAR;
            end else begin
                n_result.day_out   = gds_pkg::DAY_FIRST;
                n_result.month_out = gds_pkg::MONTH_JAN;
                n_result.year_out  = y + gds_pkg::YEAR_W'(1);
            end
        end else begin
            if (d > gds_pkg::DAY_FIRST) begin
                n_result.day_out = d - gds_pkg::DAY_W'(1);
            end else if (m != gds_pkg::MONTH_JAN) begin
                n_result.day_out   = i_stage.len_prev;
                n_result.month_out = m - gds_pkg::MONTH_W'(1);
            end else if (y == gds_pkg::YEAR_FIRST) begin
                n_result.status = gds_pkg::ST_BAD_YEAR;
            end else begin
                n_result.day_out   = gds_pkg::DAY_LAST_DEC;
                n_result.month_out = gds_pkg::MONTH_DEC;
                n_result.year_out  = y - gds_pkg::YEAR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_stage.valid;
        end
        o_result <= n_result;
    end

endmodule

### hw/rtl/gregorian_date_stepper.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper
// Next or previous Gregorian date in a three-stage pipeline.
// ----------------------------------------------------------------------------
// Pulse start with a date and a direction; when it leaves the last stage o_done
// is high for one cycle with the stepped date and a status (ok, bad month, or
// bad year: the year is outside 1..9999 or would leave it). A new date may be
// started every cycle, so the sustained rate is one date per clock. The
// three pipeline stages are a reciprocal multiply that divides the
// year by 25, the leap year test with the month length lookup, and the day,
// month and year step itself. busy never rises, and results are not held:
// the receiver must take each one in the cycle o_done marks it. Reset only
// clears the stage valid bits; there is no state and no clearing pass.
// On an error status the input date comes back unchanged.
// ----------------------------------------------------------------------------
`include "gregorian_date_stepper_defines.svh"

module gregorian_date_stepper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gds_pkg::t_in_item  i_item,
    output logic               o_done,
    output gds_pkg::t_out_item o_result
);

    gds_pkg::t_s1 s1;
    gds_pkg::t_s2 s2;
    logic         in_xfer;

    // every stage advances each cycle, so a transfer is never refused
    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    // stage 1: divide the year by 25 through its reciprocal
    gds_year_div u_year_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_item  (i_item),
        .o_stage (s1)
    );

    // stage 2: leap year, range checks, length of this and the previous month
    gds_month_len u_month_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s1),
        .o_stage (s2)
    );

    // stage 3: step the date and hold the result for its one-cycle transfer
    gds_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (s2),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    // every accepted date produces its result on o_done after the year divide, month length and step registers
    `GDS_ASSERT_LATER(a_latency, i_clk, i_rst_n, in_xfer, 3, o_done)
    // a good result always carries a real month and a nonzero day
    `GDS_ASSERT_IMPL(a_ok_date, i_clk, i_rst_n, o_done && (o_result.status == gds_pkg::ST_OK), (o_result.month_out >= gds_pkg::MONTH_JAN) && (o_result.month_out <= gds_pkg::MONTH_DEC) && (o_result.day_out >= gds_pkg::DAY_FIRST))
    // an error returns the date that went in
    `GDS_ASSERT_IMPL(a_err_hold, i_clk, i_rst_n, o_done && (o_result.status != gds_pkg::ST_OK), (o_result.day_out == $past(i_item.day_in, 3)) && (o_result.month_out == $past(i_item.month_in, 3)) && (o_result.year_out == $past(i_item.year_in, 3)))
    // a bad month is reported exactly when the month that went in was bad
    `GDS_ASSERT_IMPL(a_bad_month, i_clk, i_rst_n, o_done, (o_result.status == gds_pkg::ST_BAD_MONTH) == (($past(i_item.month_in, 3) < gds_pkg::MONTH_JAN) || ($past(i_item.month_in, 3) > gds_pkg::MONTH_DEC)))

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gregorian date stepper testbench
// Drives directed and random dates through gregorian_date_stepper with random
// gaps between transfers and checks every result against a calendar
// predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the stepped date for every input transfer and
    // compares each strobed result, in order, with the oldest prediction.
    // ------------------------------------------------------------------------
    class date_scoreboard;
        gds_pkg::t_out_item expected_dates[$];
        int unsigned        transfers;
        int unsigned        results;
        int unsigned        mismatches;
        int unsigned        orphans;
        int unsigned        reported;
        int unsigned        status_seen[3];

        function bit is_leap(int y);
            return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
        endfunction

        function int month_length(int m, int y);
            int len;
            len = 31;
            if (m == gds_pkg::MONTH_FEB) begin
                len = is_leap(y) ? 29 : 28;
            end else if (m == gds_pkg::MONTH_APR || m == gds_pkg::MONTH_JUN ||
                         m == gds_pkg::MONTH_SEP || m == gds_pkg::MONTH_NOV) begin
                len = 30;
            end
            return len;
        endfunction

        // Next or previous calendar date; on any error return the input date.
        function gds_pkg::t_out_item step_date(gds_pkg::t_in_item it);
            int                 d, m, y, nd, nm, ny, ymax;
            gds_pkg::t_status   st;
            gds_pkg::t_out_item r;
            d    = it.day_in;
            m    = it.month_in;
            y    = it.year_in;
            ymax = gds_pkg::YEAR_LIMIT;
            nd   = d;
            nm   = m;
            ny   = y;
            st   = gds_pkg::ST_OK;
            if (m < gds_pkg::MONTH_JAN || m > gds_pkg::MONTH_DEC) begin
                st = gds_pkg::ST_BAD_MONTH;
            end else if (y < 1 || y > ymax) begin
                st = gds_pkg::ST_BAD_YEAR;
            end else if (it.action == gds_pkg::ACT_NEXT) begin
                if (d < month_length(m, y)) begin
                    nd = d + 1;
                end else begin
                    nd = 1;
                    nm = m + 1;
                    if (nm > gds_pkg::MONTH_DEC) begin
                        nm = gds_pkg::MONTH_JAN;
                        ny = y + 1;
                    end
                end
            end else begin
                if (d > 1) begin
                    nd = d - 1;
                end else begin
                    nm = m - 1;
                    if (nm == 0) begin
                        nm = gds_pkg::MONTH_DEC;
                        ny = y - 1;
                    end
                    if (ny >= 1) nd = month_length(nm, ny);
                end
            end
            if (st == gds_pkg::ST_OK && (ny < 1 || ny > ymax)) st = gds_pkg::ST_BAD_YEAR;
            if (st != gds_pkg::ST_OK) begin
                nd = d;
                nm = m;
                ny = y;
            end
            r.day_out   = gds_pkg::DAY_W'(nd);
            r.month_out = gds_pkg::MONTH_W'(nm);
            r.year_out  = gds_pkg::YEAR_W'(ny);
            r.status    = st;
            return r;
        endfunction

        function void note_transfer(gds_pkg::t_in_item it);
            transfers++;
            expected_dates.push_back(step_date(it));
        endfunction

        function void check_result(gds_pkg::t_out_item got);
            gds_pkg::t_out_item want;
            bit                 bad_day, bad_month, bad_year, bad_status;
            results++;
            if (got.status <= gds_pkg::ST_BAD_YEAR) status_seen[got.status]++;
            if (expected_dates.size() == 0) begin
                orphans++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: result with nothing expected: %0d/%0d/%0d status %0d",
                             $realtime, got.day_out, got.month_out, got.year_out,
                             got.status);
                end
                return;
            end
            want       = expected_dates.pop_front();
            bad_day    = got.day_out   !== want.day_out;
            bad_month  = got.month_out !== want.month_out;
            bad_year   = got.year_out  !== want.year_out;
            bad_status = got.status    !== want.status;
            if (bad_day || bad_month || bad_year || bad_status) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display({"%0t: mismatch%s%s%s%s: expected %0d/%0d/%0d st %0d,",
                              " got %0d/%0d/%0d st %0d"},
                             $realtime,
                             bad_day ? " day" : "", bad_month ? " month" : "",
                             bad_year ? " year" : "", bad_status ? " status" : "",
                             want.day_out, want.month_out, want.year_out, want.status,
                             got.day_out, got.month_out, got.year_out, got.status);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals. Hold every input at a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    gds_pkg::t_in_item  i_item  = '0;
    logic               o_done;
    gds_pkg::t_out_item o_result;

    date_scoreboard sb = new();

    always #1 i_clk = ~i_clk;

    gregorian_date_stepper dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Monitor: at each rising edge the sampled values are the ones from the
    // cycle that just ended, since every input is driven with nonblocking
    // assignments. A transfer happens when start is high and busy is low.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_transfer(i_item);
            if (o_done) sb.check_result(o_result);
        end
    end

    // Watchdog: far beyond the slowest legal run (424 items, long gaps).
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Each one is entered right after a rising edge and returns
    // right after one, so no signal gets two assignments in one time step.
    // ------------------------------------------------------------------------

    // Present one date and hold it until the block takes the transfer.
    task automatic send_date(input gds_pkg::t_in_item item);
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for a number of cycles with junk on the item bus.
    task automatic idle_cycles(input int unsigned n);
        if (n > 0) begin
            start  <= 1'b0;
            i_item <= gds_pkg::t_in_item'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every predicted date has been checked.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly back to back or short gaps, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic gds_pkg::t_in_item make_date(input logic act, input int d,
                                                    input int m, input int y);
        gds_pkg::t_in_item it;
        it.action   = act;
        it.day_in   = gds_pkg::DAY_W'(d);
        it.month_in = gds_pkg::MONTH_W'(m);
        it.year_in  = gds_pkg::YEAR_W'(y);
        return it;
    endfunction

    // Mostly well-formed date (the day may be zero), biased toward month ends, year ends and leap rules.
    function automatic gds_pkg::t_in_item random_date();
        int m, y, d, len, r;
        r = $urandom_range(0, 15);
        if (r < 2)       y = $urandom_range(0, 1) ? $urandom_range(1, 2)
                                                  : $urandom_range(gds_pkg::YEAR_LIMIT - 1,
                                                                   gds_pkg::YEAR_LIMIT);
        else if (r < 4)  y = $urandom_range(1, 99) * 100;
        else if (r < 6)  y = $urandom_range(1, 2499) * 4;
        else             y = $urandom_range(1, gds_pkg::YEAR_LIMIT);
        r = $urandom_range(0, 7);
        if (r == 0)      m = gds_pkg::MONTH_JAN;
        else if (r == 1) m = gds_pkg::MONTH_DEC;
        else if (r == 2) m = gds_pkg::MONTH_FEB;
        else             m = $urandom_range(gds_pkg::MONTH_JAN, gds_pkg::MONTH_DEC);
        len = sb.month_length(m, y);
        r = $urandom_range(0, 5);
        if (r < 2)       d = $urandom_range(len - 1, len);
        else if (r == 2) d = $urandom_range(0, 1);
        else             d = $urandom_range(1, len);
        return make_date(1'($urandom_range(0, 1)), d, m, y);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        gds_pkg::t_in_item directed[$];
        gds_pkg::t_in_item item;
        int unsigned       burst_left;
        int unsigned       n_random;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Year rollover at both ends of the range.
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 31, gds_pkg::MONTH_DEC,
                                     gds_pkg::YEAR_LIMIT - 1));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 31, gds_pkg::MONTH_DEC,
                                     gds_pkg::YEAR_LIMIT));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 1, gds_pkg::MONTH_JAN, 1));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 1, gds_pkg::MONTH_JAN, 2));
        // Leap rule: divisible by 4, by 100, by 400.
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 28, gds_pkg::MONTH_FEB, 2024));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 29, gds_pkg::MONTH_FEB, 2024));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 28, gds_pkg::MONTH_FEB, 1900));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 28, gds_pkg::MONTH_FEB, 2000));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 1, 3, 2000));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 1, 3, 1900));
        // Month out of range, including the all-ones fields.
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 15, 0, 2023));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 1, 13, 2023));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 31, 15, 16383));
        // Year out of range with a valid month.
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 10, gds_pkg::MONTH_JUN, 0));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 10, gds_pkg::MONTH_JUN,
                                     gds_pkg::YEAR_LIMIT + 1));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 31, gds_pkg::MONTH_DEC, 16383));
        // Day beyond the month length rolls over going forward.
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 31, gds_pkg::MONTH_FEB, 2023));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 31, gds_pkg::MONTH_APR, 2023));
        // Day zero in both directions.
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 0, 7, 2023));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 0, 3, 2023));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 0, gds_pkg::MONTH_JAN, 1));
        // Plain steps, and one more year out of range.
        directed.push_back(make_date(gds_pkg::ACT_PREV, 31, 8, 1999));
        directed.push_back(make_date(gds_pkg::ACT_NEXT, 30, gds_pkg::MONTH_NOV, 1234));
        directed.push_back(make_date(gds_pkg::ACT_PREV, 31, 5, 16383));

        foreach (directed[i]) begin
            send_date(directed[i]);
            idle_cycles(pick_gap());
        end
        drain_results();

        // Random part: mostly well-formed dates, a fifth pure noise, with
        // occasional bursts of back-to-back transfers.
        burst_left = 0;
        n_random   = 400;
        for (int unsigned k = 0; k < n_random; k++) begin
            if ($urandom_range(0, 4) == 0) item = gds_pkg::t_in_item'($urandom);
            else                           item = random_date();
            send_date(item);
            if (k == n_random / 2) begin
                drain_results();
            end else if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 29) == 0) begin
                burst_left = $urandom_range(10, 40);
            end else begin
                idle_cycles(pick_gap());
            end
        end

        // Let the pipeline empty, then a few more cycles for stray strobes.
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d dates over %0d transfers: %0d ok, %0d bad month, %0d bad year.",
                 sb.results, sb.transfers, sb.status_seen[gds_pkg::ST_OK],
                 sb.status_seen[gds_pkg::ST_BAD_MONTH], sb.status_seen[gds_pkg::ST_BAD_YEAR]);
        $display("Mismatches %0d, unexpected results %0d, missing results %0d.",
                 sb.mismatches, sb.orphans, sb.pending());
        if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### gregorian_date_stepper.f
+incdir+hw/rtl
hw/rtl/gds_pkg.sv
hw/rtl/gds_year_div.sv
hw/rtl/gds_month_len.sv
hw/rtl/gds_step.sv
hw/rtl/gregorian_date_stepper.sv
dv/testbench.sv
